// ===== design/av_ti_pkg.sv =====
// Shared types and constants for the audio/video timestamp interleaver.
`timescale 1ns / 1ps

package av_ti_pkg;

  localparam int STAMP_W = 32;
  localparam int LEN_W   = 24;
  localparam int REF_W   = 32;

  localparam int VLIMIT_W = 5;
  localparam int ALIMIT_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [VLIMIT_W-1:0] VLIMIT_RESET = 5'd25;
  localparam logic [ALIMIT_W-1:0] ALIMIT_RESET = 6'd44;

  typedef enum logic [1:0] {
    FUNC_PUSH_VIDEO = 2'd0,
    FUNC_PUSH_AUDIO = 2'd1,
    FUNC_POP        = 2'd2,
    FUNC_UNUSED     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CHOSEN_NONE  = 2'd0,
    CHOSEN_VIDEO = 2'd1,
    CHOSEN_AUDIO = 2'd2,
    CHOSEN_RSVD  = 2'd3
  } chosen_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIDEO_EN    = 2'd0,
    CFG_AUDIO_EN    = 2'd1,
    CFG_VIDEO_LIMIT = 2'd2,
    CFG_AUDIO_LIMIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [STAMP_W-1:0] stamp;
    logic [LEN_W-1:0]          len;
    logic [REF_W-1:0]          buf_ref;
  } desc_t;

  // Queue status seen by the head selector.
  typedef struct packed {
    logic nonempty;
    logic over;
    logic can_push;
  } q_stat_t;

endpackage

// ===== design/av_ti_queue.sv =====
// Descriptor FIFO with prefetched, registered head entry and backlog flags.
`timescale 1ns / 1ps

module av_ti_queue #(
  parameter int DEPTH   = 64,
  parameter int LIMIT_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 pop_i,
  input  av_ti_pkg::desc_t     wr_desc_i,
  input  logic [LIMIT_W-1:0]   limit_i,
  output av_ti_pkg::desc_t     head_o,
  output av_ti_pkg::q_stat_t   stat_o
);
  import av_ti_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > LIMIT_W + 1) ? CW : LIMIT_W + 1;

  desc_t         mem [DEPTH];
  desc_t         head_q;
  logic [IW-1:0] head_q_idx, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [CMPW-1:0] count_ext, limit_ext;

  assign count_ext = CMPW'(count_q);
  assign limit_ext = CMPW'(limit_i);

  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.over     = (count_ext > limit_ext);
  assign stat_o.can_push = (count_ext <= (limit_ext << 1)) && (count_q < CW'(DEPTH));

  always_comb begin
    head_d  = head_q_idx;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d  = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (pop_i) begin
      head_d  = (head_q_idx == IW'(DEPTH - 1)) ? '0 : head_q_idx + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q_idx <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else begin
      head_q_idx <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
    end
  end

  // Prefetch the next head; forward a push that lands in the head slot.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= wr_desc_i;
    end
    if (push_i && (tail_q == head_d)) begin
      head_q <= wr_desc_i;
    end else begin
      head_q <= mem[head_d];
    end
  end

  assign head_o = head_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CW'(DEPTH)))
    else $error("push into full queue");
  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && pop_i))
    else $error("push and pop in one cycle");

endmodule

// ===== design/av_ti_select.sv =====
// Head selection between the video and audio queues.
`timescale 1ns / 1ps

module av_ti_select (
  input  av_ti_pkg::q_stat_t   vstat_i,
  input  av_ti_pkg::q_stat_t   astat_i,
  input  logic signed [31:0]   vstamp_i,
  input  logic signed [31:0]   astamp_i,
  input  logic                 video_en_i,
  input  logic                 audio_en_i,
  output av_ti_pkg::chosen_e   pick_o
);
  import av_ti_pkg::*;

  always_comb begin
    priority if (vstat_i.nonempty && astat_i.nonempty) begin
      // ties go to audio
      pick_o = (vstamp_i < astamp_i) ? CHOSEN_VIDEO : CHOSEN_AUDIO;
    end else if (vstat_i.nonempty && (!audio_en_i || vstat_i.over)) begin
      pick_o = CHOSEN_VIDEO;
    end else if (astat_i.nonempty && (!video_en_i || astat_i.over)) begin
      pick_o = CHOSEN_AUDIO;
    end else begin
      pick_o = CHOSEN_NONE;
    end
  end

endmodule

// ===== design/av_timestamp_interleaver_core.sv =====
// Top level: config registers, two descriptor queues, selector, result register.
//
//  channel   signals                                  direction
//  --------  ---------------------------------------  ---------
//  in        in_valid_i/in_ready_o, func, stamp, ...  sink
//  out       out_valid_o/out_ready_i, accepted, ...   source
//  cfg       cfg_we_i, cfg_idx_i, cfg_data_i          write only
//
// One beat per cycle while the output is not stalled: each beat is resolved in
// a single registered pass from the prefetched head registers of both queues
// into the result register. Reset clears head pointers, counts and valid flags
// at once; queue entries are not cleared and there is no clearing pass.
// in_ready_o is high while the result register is empty or being taken, so a
// stalled output holds at most one beat and blocks further input.
`timescale 1ns / 1ps

module av_timestamp_interleaver_core #(
  parameter int VIDEO_DEPTH = 64,
  parameter int AUDIO_DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [av_ti_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [av_ti_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             func_i,
  input  logic signed [av_ti_pkg::STAMP_W-1:0]   stamp_i,
  input  logic [av_ti_pkg::LEN_W-1:0]            pkt_len_i,
  input  logic [av_ti_pkg::REF_W-1:0]            pkt_ref_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   accepted_o,
  output logic [1:0]                             chosen_o,
  output logic signed [av_ti_pkg::STAMP_W-1:0]   out_stamp_o,
  output logic [av_ti_pkg::LEN_W-1:0]            out_len_o,
  output logic [av_ti_pkg::REF_W-1:0]            out_ref_o,
  output logic                                   video_backlog_o
);
  import av_ti_pkg::*;

  logic                video_en_q, audio_en_q;
  logic [VLIMIT_W-1:0] vlimit_q;
  logic [ALIMIT_W-1:0] alimit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_en_q <= 1'b0;
      audio_en_q <= 1'b0;
      vlimit_q   <= VLIMIT_RESET;
      alimit_q   <= ALIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VIDEO_EN:    video_en_q <= cfg_data_i[0];
        CFG_AUDIO_EN:    audio_en_q <= cfg_data_i[0];
        CFG_VIDEO_LIMIT: vlimit_q   <= cfg_data_i[VLIMIT_W-1:0];
        CFG_AUDIO_LIMIT: alimit_q   <= cfg_data_i[ALIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic    out_valid_q;
  logic    in_fire;
  func_e   func;
  desc_t   wr_desc, vhead, ahead;
  q_stat_t vstat, astat;
  chosen_e pick, chosen_d;
  logic    v_push, a_push, v_pop, a_pop;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign func       = func_e'(func_i);
  assign wr_desc    = '{stamp: stamp_i, len: pkt_len_i, buf_ref: pkt_ref_i};

  assign v_push = in_fire && (func == FUNC_PUSH_VIDEO) && vstat.can_push;
  assign a_push = in_fire && (func == FUNC_PUSH_AUDIO) && astat.can_push;
  assign chosen_d = (func == FUNC_POP) ? pick : CHOSEN_NONE;
  assign v_pop  = in_fire && (chosen_d == CHOSEN_VIDEO);
  assign a_pop  = in_fire && (chosen_d == CHOSEN_AUDIO);

  av_ti_queue #(.DEPTH(VIDEO_DEPTH), .LIMIT_W(VLIMIT_W)) u_vq (
    .clk_i, .rst_ni,
    .push_i(v_push), .pop_i(v_pop), .wr_desc_i(wr_desc),
    .limit_i(vlimit_q), .head_o(vhead), .stat_o(vstat)
  );

  av_ti_queue #(.DEPTH(AUDIO_DEPTH), .LIMIT_W(ALIMIT_W)) u_aq (
    .clk_i, .rst_ni,
    .push_i(a_push), .pop_i(a_pop), .wr_desc_i(wr_desc),
    .limit_i(alimit_q), .head_o(ahead), .stat_o(astat)
  );

  av_ti_select u_sel (
    .vstat_i(vstat), .astat_i(astat),
    .vstamp_i(vhead.stamp), .astamp_i(ahead.stamp),
    .video_en_i(video_en_q), .audio_en_i(audio_en_q),
    .pick_o(pick)
  );

  desc_t out_desc_d;
  always_comb begin
    unique case (chosen_d)
      CHOSEN_VIDEO: out_desc_d = vhead;
      CHOSEN_AUDIO: out_desc_d = ahead;
      default:      out_desc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      accepted_o      <= v_push || a_push;
      chosen_o        <= chosen_d;
      out_stamp_o     <= out_desc_d.stamp;
      out_len_o       <= out_desc_d.len;
      out_ref_o       <= out_desc_d.buf_ref;
      video_backlog_o <= (chosen_d == CHOSEN_VIDEO) && vstat.over;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
